### design/tss_pkg.sv
// Shared types and constants for the task slot scheduler.
package tss_pkg;

    localparam int TASK_SLOTS  = 16;
    localparam int SLOT_W      = $clog2(TASK_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int PRIO_W      = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    localparam logic [1:0] MODE_RR      = 2'd0;
    localparam logic [1:0] MODE_PRIO    = 2'd1;
    localparam logic [1:0] MODE_RR_PRIO = 2'd2;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_SCHED  = 1'b1;

    typedef struct packed {
        logic              ready;
        logic              idle;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MOD   = 4'b0010,
        S_SWEEP = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

### design/task_slot_scheduler.sv
// Task slot scheduler: one table memory walked slot by slot for each decision.
// Update transfer: written straight to the table, no result; the next transfer can follow at once.
// Schedule transfer: an accept step, start reduction (extra subtract steps only when the
// slot after the running one lies at or beyond the slot count), a sweep over the slots in
// use and a decision step, held while the previous result waits.
// Synchronous active-low reset: round robin mode, one slot, running slot 0, valid bits clear.
module task_slot_scheduler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // fields from bit 0: slot[3:0], ready_req[4], is_idle[5], priority_req[13:6]
    input  logic [tss_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // fields: kind[0]
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // fields from bit 0: chosen_slot[3:0]
    output logic [tss_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_index,
    input  logic [tss_pkg::CNT_W-1:0]           i_cfg_wdata
);
    import tss_pkg::*;

    t_state             r_state;
    logic [1:0]         r_mode;
    logic [CNT_W-1:0]   r_task_count;
    logic [SLOT_W-1:0]  r_run;

    t_entry             r_mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] r_vld;
    t_entry             r_rd_data;
    logic               r_rd_hit;
    logic               r_rd_en;
    logic [SLOT_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]   r_addr;
    logic [CNT_W-1:0]   r_start;

    // first eligible slot at or after start (a) and anywhere (b)
    logic               r_ea_v, r_eb_v;
    logic [SLOT_W-1:0]  r_ea_i, r_eb_i;
    logic [PRIO_W-1:0]  r_ea_p, r_eb_p;
    // highest ready priority over slots 1.., split at start
    logic               r_ma_v, r_mb_v;
    logic [SLOT_W-1:0]  r_ma_i, r_mb_i;
    logic [PRIO_W-1:0]  r_ma_p, r_mb_p;

    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;

    logic [CNT_W-1:0]   w_n;
    logic               w_in_xfer;
    t_entry             w_wr_ent;
    t_entry             w_ent;
    logic               w_elig;
    logic               w_after;
    logic [CNT_W-1:0]   w_run_ext;
    logic [CNT_W-1:0]   w_start0;
    logic               w_load;
    logic [SLOT_W-1:0]  w_pick;
    logic               w_p_v, w_m_v, w_m_sel_a, w_rp_sel_a;
    logic [SLOT_W-1:0]  w_p_i, w_m_i;
    logic [PRIO_W-1:0]  w_p_p, w_m_p;

    // slots in use: 0 acts as 1, saturate at table size
    always_comb begin
        if (r_task_count == '0) begin
            w_n = CNT_W'(1);
        end else if (r_task_count > CNT_W'(TASK_SLOTS)) begin
            w_n = CNT_W'(TASK_SLOTS);
        end else begin
            w_n = r_task_count;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_wr_ent      = '{ready: s_axis_tdata[4], idle: s_axis_tdata[5],
                             prio: s_axis_tdata[13:6]};

    assign w_run_ext = {1'b0, r_run};
    assign w_start0  = (r_mode == MODE_PRIO) ? ((w_run_ext < w_n) ? w_run_ext : '0)
                                             : w_run_ext + CNT_W'(1);

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && s_axis_tuser == KIND_UPDATE) begin
            r_mem[s_axis_tdata[SLOT_W-1:0]] <= w_wr_ent;
        end
        r_rd_data <= r_mem[r_addr[SLOT_W-1:0]];
        r_rd_hit  <= r_vld[r_addr[SLOT_W-1:0]];
        r_rd_idx  <= r_addr[SLOT_W-1:0];
    end

    // never-written slots read as cleared
    assign w_ent   = r_rd_hit ? r_rd_data : '0;
    assign w_elig  = (r_mode == MODE_PRIO) ? w_ent.ready : (w_ent.ready && !w_ent.idle);
    assign w_after = {1'b0, r_rd_idx} >= r_start;

    // decision from the sweep summary
    always_comb begin
        w_p_v      = r_ea_v || r_eb_v;
        w_p_i      = r_ea_v ? r_ea_i : r_eb_i;
        w_p_p      = r_ea_v ? r_ea_p : r_eb_p;
        // lower slots win ties for priority mode; group b holds the lower slots
        w_m_sel_a  = r_ma_v && (!r_mb_v || r_ma_p > r_mb_p);
        w_m_v      = r_ma_v || r_mb_v;
        w_m_i      = w_m_sel_a ? r_ma_i : r_mb_i;
        w_m_p      = w_m_sel_a ? r_ma_p : r_mb_p;
        // round robin order visits group a first
        w_rp_sel_a = r_ma_v && (!r_mb_v || r_ma_p >= r_mb_p);
        case (r_mode)
            MODE_PRIO: begin
                if (!w_p_v) begin
                    w_pick = '0;
                end else if (w_m_v && w_m_p > w_p_p) begin
                    w_pick = w_m_i;
                end else begin
                    w_pick = w_p_i;
                end
            end
            MODE_RR_PRIO: begin
                if (!w_m_v) begin
                    w_pick = '0;
                end else begin
                    w_pick = w_rp_sel_a ? r_ma_i : r_mb_i;
                end
            end
            default: begin
                w_pick = r_ea_v ? r_ea_i : (r_eb_v ? r_eb_i : '0);
            end
        endcase
    end

    assign w_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_RR;
            r_task_count <= CNT_W'(1);
            r_run        <= '0;
            r_vld        <= '0;
            r_rd_en      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MODE:  r_mode       <= i_cfg_wdata[1:0];
                    CFG_COUNT: r_task_count <= i_cfg_wdata;
                    default:   r_mode       <= r_mode;
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_rd_en <= 1'b0;
                    if (w_in_xfer) begin
                        if (s_axis_tuser == KIND_UPDATE) begin
                            r_vld[s_axis_tdata[SLOT_W-1:0]] <= 1'b1;
                        end else begin
                            r_start <= w_start0;
                            r_addr  <= '0;
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    // start position modulo slot count, one subtract a cycle
                    if (r_start >= w_n) begin
                        r_start <= r_start - w_n;
                    end else begin
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_addr == w_n) begin
                        r_rd_en <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_rd_en <= 1'b1;
                        r_addr  <= r_addr + CNT_W'(1);
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_out_slot  <= w_pick;
                        r_run       <= w_pick;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // sweep summary, cleared on a schedule transfer, updated as each slot's read data returns
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && s_axis_tuser == KIND_SCHED) begin
            r_ea_v <= 1'b0;
            r_eb_v <= 1'b0;
            r_ma_v <= 1'b0;
            r_mb_v <= 1'b0;
        end else if (r_rd_en) begin
            if (w_elig) begin
                if (w_after && !r_ea_v) begin
                    r_ea_v <= 1'b1;
                    r_ea_i <= r_rd_idx;
                    r_ea_p <= w_ent.prio;
                end
                if (!r_eb_v) begin
                    r_eb_v <= 1'b1;
                    r_eb_i <= r_rd_idx;
                    r_eb_p <= w_ent.prio;
                end
            end
            if (w_ent.ready && r_rd_idx != '0) begin
                if (w_after) begin
                    if (!r_ma_v || w_ent.prio > r_ma_p) begin
                        r_ma_v <= 1'b1;
                        r_ma_i <= r_rd_idx;
                        r_ma_p <= w_ent.prio;
                    end
                end else if (!r_mb_v || w_ent.prio > r_mb_p) begin
                    r_mb_v <= 1'b1;
                    r_mb_i <= r_rd_idx;
                    r_mb_p <= w_ent.prio;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-SLOT_W){1'b0}}, r_out_slot};

`ifndef SYNTH
    a_no_read_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_rd_en)
        else $error("read in flight while accepting transfers");

    a_start_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_start < w_n))
        else $error("sweep start not reduced below slot count");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> ({1'b0, w_pick} < w_n))
        else $error("chosen slot beyond slots in use");

    a_result_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (m_axis_tvalid && r_run == r_out_slot))
        else $error("result and running slot disagree");
`endif

endmodule

### sim/task_slot_scheduler_tb.sv
// Self-checking testbench for task_slot_scheduler: directed table, then random phases.
`timescale 1ns / 1ps

module task_slot_scheduler_tb;
    import tss_pkg::*;

    localparam logic [1:0] MODE_RR_ALIAS = 2'd3;  // unused code, decodes as round robin
    localparam int ITEM_TARGET  = 1750;
    localparam int SETTLE_CYCLES = 30;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic {ROW_XFER, ROW_CFG} t_row_op;

    typedef struct {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic              rdy;
        logic              idl;
        logic [PRIO_W-1:0] pri;
    } t_sched_item;

    typedef struct {
        t_row_op           op;
        t_sched_item       item;
        logic              reg_idx;
        logic [CNT_W-1:0]  reg_val;
        bit                fixed;
        logic [SLOT_W-1:0] want;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic                   i_cfg_wr_en;
    logic                   i_cfg_index;
    logic [CNT_W-1:0]       i_cfg_wdata;

    task_slot_scheduler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // shadow copy of the slot table, running slot and registers
    logic              tbl_ready [TASK_SLOTS];
    logic              tbl_idle  [TASK_SLOTS];
    logic [PRIO_W-1:0] tbl_prio  [TASK_SLOTS];
    logic [SLOT_W-1:0] cur_slot;
    logic [1:0]        cfg_mode;
    logic [CNT_W-1:0]  cfg_count;

    logic [SLOT_W-1:0] pending_picks[$];
    t_dir_row          dir_rows[$];
    int                mismatch_count = 0;
    int                items_sent = 0;
    int                tx_calm = 0;
    int                rx_calm = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [SLOT_W-1:0] predict_pick();
        int  n, p, i, t, top;
        bit  found;
        n = cfg_count;
        if (n == 0) n = 1;
        if (n > 16) n = 16;
        if (n > TASK_SLOTS) n = TASK_SLOTS;
        found = 0;
        top = 0;
        case (cfg_mode)
            MODE_PRIO: begin
                p = (cur_slot < n) ? cur_slot : 0;
                for (t = 0; t < n && !found; t++) begin
                    if (tbl_ready[p]) found = 1;
                    else p = (p + 1) % n;
                end
                if (!found) return '0;
                top = tbl_prio[p];
                // first of the strictly higher priorities from slot 1 up wins
                for (i = 1; i < n; i++) begin
                    if (tbl_ready[i] && tbl_prio[i] > top) begin
                        p = i;
                        top = tbl_prio[i];
                    end
                end
                return SLOT_W'(p);
            end
            MODE_RR_PRIO: begin
                for (i = 1; i < n; i++) begin
                    if (tbl_ready[i] && (!found || tbl_prio[i] > top)) begin
                        top = tbl_prio[i];
                        found = 1;
                    end
                end
                if (!found) return '0;
                p = cur_slot;
                for (t = 0; t < n; t++) begin
                    p = (p + 1) % n;
                    if (p != 0 && tbl_ready[p] && tbl_prio[p] == top) return SLOT_W'(p);
                end
                return '0;
            end
            default: begin
                p = cur_slot;
                for (t = 0; t < n; t++) begin
                    p = (p + 1) % n;
                    if (tbl_ready[p] && !tbl_idle[p]) return SLOT_W'(p);
                end
                return '0;
            end
        endcase
        return '0;
    endfunction

    // mostly short pauses, a few long ones, and now and then a calm stretch
    function automatic int pause_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) calm = $urandom_range(30, 150);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input t_sched_item it, input bit fixed,
                             input logic [SLOT_W-1:0] want);
        logic [SLOT_W-1:0] pick;
        int                gap;
        s_axis_tdata  <= {2'b00, it.pri, it.idl, it.rdy, it.slot};
        s_axis_tuser  <= it.kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (it.kind == KIND_SCHED) begin
            pick = predict_pick();
            cur_slot = pick;
            pending_picks.push_back(fixed ? want : pick);
        end else begin
            tbl_ready[it.slot] = it.rdy;
            tbl_idle[it.slot]  = it.idl;
            tbl_prio[it.slot]  = it.pri;
        end
        @(negedge i_clk);
        gap = pause_len(tx_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // hold the sender until every pick is back, then let in-flight work finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_picks.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CNT_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_MODE) cfg_mode = val[1:0];
        else cfg_count = val;
    endtask

    task automatic add_upd(input int slot, input logic rdy, input logic idl, input int pri);
        t_dir_row row;
        row = '{op: ROW_XFER, item: '{KIND_UPDATE, SLOT_W'(slot), rdy, idl, PRIO_W'(pri)},
                reg_idx: 1'b0, reg_val: '0, fixed: 0, want: '0};
        dir_rows.push_back(row);
    endtask

    task automatic add_sched(input bit fixed, input int want);
        t_dir_row row;
        row = '{op: ROW_XFER, item: '{KIND_SCHED, '0, 1'b0, 1'b0, '0},
                reg_idx: 1'b0, reg_val: '0, fixed: fixed, want: SLOT_W'(want)};
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic idx, input int val);
        t_dir_row row;
        row = '{op: ROW_CFG, item: '{KIND_UPDATE, '0, 1'b0, 1'b0, '0},
                reg_idx: idx, reg_val: CNT_W'(val), fixed: 0, want: '0};
        dir_rows.push_back(row);
    endtask

    // result side: random stalls, check each transfer against the oldest pick
    initial begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                stall = pause_len(rx_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        logic [SLOT_W-1:0] exp_slot;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_picks.size() == 0) begin
                $display("%0t: unexpected result, expected none, got slot %0d",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                exp_slot = pending_picks.pop_front();
                if (m_axis_tdata !== {{(OUT_TDATA_W-SLOT_W){1'b0}}, exp_slot}) begin
                    $display("%0t: chosen_slot mismatch, expected %0d, got %0d",
                             $time, exp_slot, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("%0t: watchdog expired", $time);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_sched_item it;
        int          n, r, len, k, i;
        i_rst_n       = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tvalid = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_MODE;
        i_cfg_wdata   = '0;
        for (i = 0; i < TASK_SLOTS; i++) begin
            tbl_ready[i] = 1'b0;
            tbl_idle[i]  = 1'b0;
            tbl_prio[i]  = '0;
        end
        cur_slot  = '0;
        cfg_mode  = MODE_RR;
        cfg_count = CNT_W'(1);

        // directed table
        add_sched(1, 0);                    // empty table, one slot in use
        add_cfg(CFG_COUNT, 16);
        add_upd(15, 1'b1, 1'b0, 255);
        add_upd(5, 1'b1, 1'b1, 0);          // idle mark: skipped by round robin
        add_sched(1, 15);
        add_sched(1, 15);                   // lone candidate comes back after a full lap
        add_upd(0, 1'b1, 1'b0, 128);
        add_sched(0, 0);
        add_cfg(CFG_MODE, MODE_PRIO);
        add_sched(1, 15);                   // top priority wins
        add_upd(15, 1'b0, 1'b0, 255);
        add_upd(5, 1'b0, 1'b1, 0);
        add_sched(0, 0);
        add_upd(0, 1'b0, 1'b0, 128);
        add_sched(1, 0);                    // nothing ready in priority mode
        add_cfg(CFG_COUNT, 0);              // acts as one slot
        add_upd(3, 1'b1, 1'b0, 200);
        add_sched(1, 0);
        add_cfg(CFG_COUNT, 31);             // saturates to all slots
        add_sched(0, 0);
        add_cfg(CFG_MODE, MODE_RR_PRIO);
        add_upd(7, 1'b1, 1'b0, 200);
        add_upd(0, 1'b1, 1'b0, 255);        // slot 0 never counts here
        add_sched(0, 0);
        add_sched(0, 0);
        add_sched(0, 0);
        add_cfg(CFG_COUNT, 4);              // running slot now beyond the count
        add_cfg(CFG_MODE, MODE_PRIO);
        add_sched(0, 0);
        add_cfg(CFG_MODE, MODE_RR_ALIAS);
        add_sched(0, 0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].op == ROW_CFG) begin
                drain();
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            end else begin
                send_item(dir_rows[k].item, dir_rows[k].fixed, dir_rows[k].want);
            end
        end

        // random phases, each may rewrite the mode and the slot count
        while (items_sent < ITEM_TARGET) begin
            drain();
            r = $urandom_range(0, 99);
            if (r < 80) write_reg(CFG_MODE, CNT_W'($urandom_range(0, 3)));
            r = $urandom_range(0, 99);
            if (r < 15)      write_reg(CFG_COUNT, CNT_W'(16));
            else if (r < 22) write_reg(CFG_COUNT, CNT_W'(1));
            else if (r < 27) write_reg(CFG_COUNT, CNT_W'(0));
            else if (r < 35) write_reg(CFG_COUNT, CNT_W'($urandom_range(17, 31)));
            else if (r < 85) write_reg(CFG_COUNT, CNT_W'($urandom_range(2, 15)));
            n = cfg_count;
            if (n == 0) n = 1;
            if (n > 16) n = 16;
            len = $urandom_range(20, 120);
            for (k = 0; k < len; k++) begin
                it.kind = ($urandom_range(0, 99) < 45) ? KIND_SCHED : KIND_UPDATE;
                it.slot = ($urandom_range(0, 9) < 8) ? SLOT_W'($urandom_range(0, n - 1))
                                                     : SLOT_W'($urandom_range(0, 15));
                it.rdy  = ($urandom_range(0, 99) < 65);
                it.idl  = ($urandom_range(0, 99) < 20);
                // a small set of priorities makes ties common
                case ($urandom_range(0, 7))
                    0:       it.pri = 8'd0;
                    1:       it.pri = 8'd255;
                    2, 3:    it.pri = PRIO_W'(100 * $urandom_range(0, 2));
                    default: it.pri = PRIO_W'($urandom_range(0, 255));
                endcase
                send_item(it, 0, '0);
                if ($urandom_range(0, 59) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_picks.size() != 0) @(negedge i_clk);
                    @(negedge i_clk);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_picks.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
